@@ hw/rtl/rcst_pkg.sv @@
// Shared types and constants of the RC stick trim and aux channel mapper.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rcst_pkg;

  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned STICK_OUT_W = 12;
  localparam int unsigned AUX_OUT_W   = 11;
  localparam int unsigned TRIM_W      = 8;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned STATE_W     = 3;
  localparam int unsigned LANES       = 4;
  localparam int unsigned LANE_W      = 2;

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 96;

  // Converter full scale and the split point of the piecewise stick curve.
  localparam int unsigned SAMPLE_MAX = 1023;
  localparam int unsigned MAP_MID    = SAMPLE_MAX / 2;
  // Upper half divides by SAMPLE_MAX - MAP_MID = 2**MAP_SHIFT.
  localparam int unsigned MAP_SHIFT  = 9;

  localparam int unsigned BUTTONS = 5;

  localparam logic [AUX_OUT_W-1:0]   PULSE_MIN = 11'd1000;
  localparam logic [AUX_OUT_W-1:0]   PULSE_MID = 11'd1500;
  localparam logic [AUX_OUT_W-1:0]   PULSE_MAX = 11'd2000;
  localparam logic [STICK_OUT_W-1:0] STICK_SAT = 12'd3000;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FLUSH
  } rcst_state_e;

  typedef struct packed {
    logic              capture;
    logic              calc;
    logic [LANE_W-1:0] lane;
    logic              load;
  } rcst_cmd_t;

  // A state count above eight acts as eight.
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] c);
    eff_count = (c > COUNT_SAT) ? COUNT_SAT : c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rc_stick_trim_aux_channel_mapper_unit.sv @@
// Top level of the RC stick trim and aux channel mapper.
// Depends on rcst_pkg, rcst_ctrl, rcst_datapath and rcst_map.
//
// Usage: one stream transaction on the slave side carries a full sample set
// (four sticks, four aux samples, aux pin levels) and, when s_axis_tuser is 1,
// one button press that is applied before the set is mapped. Every input
// transaction yields exactly one master-side transaction with eight channel
// pulse widths plus trim mode and trim selection.
// Settings are written through cfg_we_i/cfg_index_i/cfg_data_i while the
// block is idle; a write takes effect at the clock edge it is sampled on.
// Timing: the press is applied at the accepting edge, then one shared lane
// per cycle maps a stick and an aux channel, then the staged results move
// into the output register, which sets m_axis_tvalid. A new item is taken
// only once the last one has been loaded into the output register, after its
// accept, its four lane passes through the shared map units and its load.
// Stall: the output register holds its transaction until m_axis_tready; the
// next item can still be accepted and worked, and it waits in the staging
// registers until the output register frees up.
// Reset: settings return to state count 2, step 1, limit 20; trims, switch
// states, trim mode and selection clear; no output is pending.
`default_nettype none

module rc_stick_trim_aux_channel_mapper_unit
  import rcst_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Slave side
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // button[2:0], throttle_raw[12:3], yaw_raw[22:13], pitch_raw[32:23],
  // roll_raw[42:33], aux1_raw[52:43], aux2_raw[62:53], aux3_raw[72:63],
  // aux4_raw[82:73], aux_levels[86:83], zero[87]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // command[0]
  input  wire logic                  s_axis_tuser,
  // Master side
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // throttle_out[11:0], yaw_out[23:12], pitch_out[35:24], roll_out[47:36],
  // aux1_out[58:48], aux2_out[69:59], aux3_out[80:70], aux4_out[91:81],
  // trim_mode[92], trim_select[94:93], zero[95]
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [6:0]            cfg_data_i
);

  rcst_cmd_t cmd;

  // Sequence accept, lane passes and output load.
  rcst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Hold settings and state, compute one lane per cycle.
  rcst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/rcst_map.sv @@
// Piecewise stick curve: sample onto 1000..1500..2000 microseconds.
// Depends on rcst_pkg.
`default_nettype none

module rcst_map
  import rcst_pkg::*;
(
  input  wire logic [SAMPLE_W-1:0]  sample_i,
  output logic      [AUX_OUT_W-1:0] pulse_o
);

  logic [SAMPLE_W-1:0]  v;
  logic [17:0]          lo_prod;
  logic [8:0]           lo_q0;
  logic [9:0]           lo_rem;
  logic [8:0]           lo_q;
  logic [SAMPLE_W-1:0]  hi_diff;
  logic [17:0]          hi_prod;
  logic [8:0]           hi_q;

  always_comb begin
    v = (sample_i > SAMPLE_W'(SAMPLE_MAX)) ? SAMPLE_W'(SAMPLE_MAX) : sample_i;

    // Lower half: v*500/511. With x = 512*q0 + lo, x = 511*q0 + (lo + q0),
    // and that remainder stays below 2*511, so one correction step suffices.
    lo_prod = 18'(v) * 18'd500;
    lo_q0   = lo_prod[17:MAP_SHIFT];
    lo_rem  = {1'b0, lo_prod[MAP_SHIFT-1:0]} + {1'b0, lo_q0};
    lo_q    = lo_q0 + ((lo_rem >= 10'(MAP_MID)) ? 9'd1 : 9'd0);

    // Upper half divides by a power of two.
    hi_diff = v - SAMPLE_W'(MAP_MID);
    hi_prod = 18'(hi_diff) * 18'd500;
    hi_q    = hi_prod[17:MAP_SHIFT];

    if (v < SAMPLE_W'(MAP_MID)) begin
      pulse_o = PULSE_MIN + {2'b00, lo_q};
    end else begin
      pulse_o = PULSE_MID + {2'b00, hi_q};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rcst_ctrl.sv @@
// Sequencer of the mapper: handshakes, lane counter and output valid.
// Depends on rcst_pkg.
`default_nettype none

module rcst_ctrl
  import rcst_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rcst_cmd_t cmd_o
);

  rcst_state_e       state_q, state_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (lane_q == LANE_W'(LANES - 1)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc    = (state_q == ST_CALC);
    cmd_o.lane    = lane_q;
    cmd_o.load    = (state_q == ST_FLUSH) && out_free;
    lane_d        = (state_q == ST_CALC) ? lane_q + 1'b1 : '0;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rcst_datapath.sv @@
// Datapath of the mapper: settings, trim and switch state, lane arithmetic,
// result staging and output register. Depends on rcst_pkg and rcst_map.
`default_nettype none

module rcst_datapath
  import rcst_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [2:0]            cfg_index_i,
  input  wire logic [6:0]            cfg_data_i,
  input  wire rcst_cmd_t             cmd_i,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic                  in_user_i,
  output logic      [OUT_DATA_W-1:0] out_data_o
);

  localparam logic [2:0] CFG_AUX4_COUNT = 3'd3;
  localparam logic [2:0] CFG_TRIM_STEP  = 3'd4;
  localparam logic [2:0] CFG_TRIM_LIMIT = 3'd5;

  localparam logic [2:0] BTN_FUNC     = 3'd0;
  localparam logic [2:0] BTN_TRIM_DN  = 3'd1;
  localparam logic [2:0] BTN_TRIM_UP  = 3'd2;
  localparam logic [2:0] BTN_SEL_NEXT = 3'd3;
  localparam logic [2:0] BTN_SEL_PREV = 3'd4;

  // Switch positions: row is state count minus two, column the state.
  localparam logic [AUX_OUT_W-1:0] AUX_LUT [7][8] = '{
    '{11'd1000, 11'd2000, 11'd2000, 11'd2000, 11'd2000, 11'd2000, 11'd2000, 11'd2000},
    '{11'd1000, 11'd1500, 11'd2000, 11'd2000, 11'd2000, 11'd2000, 11'd2000, 11'd2000},
    '{11'd1000, 11'd1333, 11'd1666, 11'd2000, 11'd2000, 11'd2000, 11'd2000, 11'd2000},
    '{11'd1000, 11'd1250, 11'd1500, 11'd1750, 11'd2000, 11'd2000, 11'd2000, 11'd2000},
    '{11'd1000, 11'd1200, 11'd1400, 11'd1600, 11'd1800, 11'd2000, 11'd2000, 11'd2000},
    '{11'd1000, 11'd1166, 11'd1333, 11'd1500, 11'd1666, 11'd1833, 11'd2000, 11'd2000},
    '{11'd1000, 11'd1142, 11'd1285, 11'd1428, 11'd1571, 11'd1714, 11'd1857, 11'd2000}
  };

  function automatic logic signed [TRIM_W-1:0] clamp_trim(input logic signed [8:0] t,
                                                          input logic [6:0] lim);
    logic signed [8:0] lim_s;
    lim_s = $signed({2'b00, lim});
    if (t > lim_s) begin
      clamp_trim = TRIM_W'(lim_s);
    end else if (t < -lim_s) begin
      clamp_trim = TRIM_W'(-lim_s);
    end else begin
      clamp_trim = TRIM_W'(t);
    end
  endfunction

  // Output lanes run throttle, yaw, pitch, roll; trims are indexed yaw first.
  function automatic logic [LANE_W-1:0] trim_index(input logic [LANE_W-1:0] lane);
    trim_index = {lane[1], lane[0] ^ ~lane[1]};
  endfunction

  // Settings
  logic [COUNT_W-1:0] aux_count_q [LANES];
  logic [3:0]         step_q;
  logic [6:0]         limit_q;

  // Trim and switch state
  logic                     trim_active_q, trim_active_d;
  logic [LANE_W-1:0]        sel_q, sel_d;
  logic [STATE_W-1:0]       aux_state_q [LANES];
  logic [STATE_W-1:0]       aux_state_d [LANES];
  logic signed [TRIM_W-1:0] trim_q [LANES];
  logic signed [TRIM_W-1:0] trim_d [LANES];

  // Captured samples
  logic [SAMPLE_W-1:0] stick_raw_q [LANES];
  logic [SAMPLE_W-1:0] aux_raw_q [LANES];
  logic [3:0]          levels_q;

  // Staged results and output register
  logic [STICK_OUT_W-1:0] stick_res_q [LANES];
  logic [AUX_OUT_W-1:0]   aux_res_q [LANES];
  logic [STICK_OUT_W-1:0] stick_out_q [LANES];
  logic [AUX_OUT_W-1:0]   aux_out_q [LANES];
  logic                   mode_out_q;
  logic [LANE_W-1:0]      sel_out_q;

  // Button handling
  logic [2:0]         button;
  logic               press_en;
  logic [LANE_W-1:0]  aux_sel;
  logic [COUNT_W-1:0] press_cnt;
  logic signed [8:0]  trim_up, trim_dn;
  logic [STATE_W:0]   next_state;

  // Lane arithmetic
  logic [AUX_OUT_W-1:0]     stick_map, aux_map;
  logic signed [TRIM_W-1:0] lane_trim;
  logic signed [12:0]       trim_prod;
  logic signed [13:0]       stick_sum;
  logic [STICK_OUT_W-1:0]   stick_val;
  logic [COUNT_W-1:0]       lane_cnt;
  logic [AUX_OUT_W-1:0]     aux_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) aux_count_q[i] <= 4'd2;
      step_q  <= 4'd1;
      limit_q <= 7'd20;
    end else if (cfg_we_i) begin
      if (cfg_index_i <= CFG_AUX4_COUNT) begin
        aux_count_q[cfg_index_i[LANE_W-1:0]] <= cfg_data_i[COUNT_W-1:0];
      end else if (cfg_index_i == CFG_TRIM_STEP) begin
        step_q <= cfg_data_i[3:0];
      end else if (cfg_index_i == CFG_TRIM_LIMIT) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  assign button   = in_data_i[2:0];
  assign press_en = cmd_i.capture && in_user_i;

  always_comb begin
    trim_active_d = trim_active_q;
    sel_d         = sel_q;
    aux_state_d   = aux_state_q;
    trim_d        = trim_q;
    aux_sel       = LANE_W'(button - 3'd1);
    press_cnt     = eff_count(aux_count_q[aux_sel]);
    trim_up       = {trim_q[sel_q][TRIM_W-1], trim_q[sel_q]} + $signed({5'b00000, step_q});
    trim_dn       = {trim_q[sel_q][TRIM_W-1], trim_q[sel_q]} - $signed({5'b00000, step_q});
    next_state    = {1'b0, aux_state_q[aux_sel]} + 1'b1;
    if (next_state > press_cnt - 1'b1) next_state = '0;

    // Ignore unknown buttons and aux buttons that are not fitted.
    if (press_en && (button < 3'(BUTTONS)) && (button <= BTN_SEL_PREV)) begin
      if (button == BTN_FUNC) begin
        trim_active_d = !trim_active_q;
        sel_d         = '0;
      end else if (press_cnt > 4'd1) begin
        if (trim_active_q) begin
          unique case (button)
            BTN_TRIM_DN:  trim_d[sel_q] = clamp_trim(trim_dn, limit_q);
            BTN_TRIM_UP:  trim_d[sel_q] = clamp_trim(trim_up, limit_q);
            BTN_SEL_NEXT: sel_d = sel_q + 1'b1;
            BTN_SEL_PREV: sel_d = sel_q - 1'b1;
            default:      ;
          endcase
        end else begin
          aux_state_d[aux_sel] = next_state[STATE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_active_q <= 1'b0;
      sel_q         <= '0;
      for (int i = 0; i < LANES; i++) begin
        aux_state_q[i] <= '0;
        trim_q[i]      <= '0;
      end
    end else begin
      trim_active_q <= trim_active_d;
      sel_q         <= sel_d;
      aux_state_q   <= aux_state_d;
      trim_q        <= trim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < LANES; i++) begin
        stick_raw_q[i] <= in_data_i[3 + SAMPLE_W*i +: SAMPLE_W];
        aux_raw_q[i]   <= in_data_i[43 + SAMPLE_W*i +: SAMPLE_W];
      end
      levels_q <= in_data_i[86:83];
    end
  end

  rcst_map u_stick_map (
    .sample_i (stick_raw_q[cmd_i.lane]),
    .pulse_o  (stick_map)
  );

  rcst_map u_aux_map (
    .sample_i (aux_raw_q[cmd_i.lane]),
    .pulse_o  (aux_map)
  );

  always_comb begin
    lane_trim = trim_q[trim_index(cmd_i.lane)];
    trim_prod = lane_trim * $signed({1'b0, step_q});
    stick_sum = $signed({3'b000, stick_map}) + {trim_prod[12], trim_prod};
    if (stick_sum < 0) begin
      stick_val = '0;
    end else if (stick_sum > $signed({2'b00, STICK_SAT})) begin
      stick_val = STICK_SAT;
    end else begin
      stick_val = stick_sum[STICK_OUT_W-1:0];
    end

    lane_cnt = eff_count(aux_count_q[cmd_i.lane]);
    if (lane_cnt == 4'd0) begin
      aux_val = aux_map;
    end else if (lane_cnt == 4'd1) begin
      aux_val = levels_q[cmd_i.lane] ? PULSE_MAX : PULSE_MIN;
    end else begin
      aux_val = AUX_LUT[3'(lane_cnt - 4'd2)][aux_state_q[cmd_i.lane]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      stick_res_q[cmd_i.lane] <= stick_val;
      aux_res_q[cmd_i.lane]   <= aux_val;
    end
    if (cmd_i.load) begin
      stick_out_q <= stick_res_q;
      aux_out_q   <= aux_res_q;
      mode_out_q  <= trim_active_q;
      sel_out_q   <= sel_q;
    end
  end

  always_comb begin
    out_data_o = '0;
    for (int i = 0; i < LANES; i++) begin
      out_data_o[STICK_OUT_W*i +: STICK_OUT_W] = stick_out_q[i];
      out_data_o[48 + AUX_OUT_W*i +: AUX_OUT_W] = aux_out_q[i];
    end
    out_data_o[92]    = mode_out_q;
    out_data_o[94:93] = sel_out_q;
  end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for rc_stick_trim_aux_channel_mapper_unit.
// Depends on rcst_pkg for widths and curve constants; a local predictor of trims,
// switch states and channel pulses checks every master-side transaction.
`default_nettype none

module testbench;
  import rcst_pkg::*;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 5;
  // Accept to m_axis_tvalid; the settle margin is a multiple of it.
  localparam int RESULT_LATENCY = 5;
  localparam int SETTLE_CYCLES  = 4 * RESULT_LATENCY;
  localparam int HOLD_CYCLES    = 300;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int PHASE_ITEMS    = 650;

  // Command carried in tuser.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_PRESS  = 1'b1;

  // Button indexes; in trim mode the aux buttons take the trim roles.
  localparam logic [2:0] BTN_FUNCTION  = 3'd0;
  localparam logic [2:0] BTN_AUX1      = 3'd1;
  localparam logic [2:0] BTN_AUX2      = 3'd2;
  localparam logic [2:0] BTN_AUX3      = 3'd3;
  localparam logic [2:0] BTN_AUX4      = 3'd4;
  localparam logic [2:0] BTN_NONE_5    = 3'd5;
  localparam logic [2:0] BTN_NONE_7    = 3'd7;
  localparam logic [2:0] BTN_TRIM_DOWN = BTN_AUX1;
  localparam logic [2:0] BTN_TRIM_UP   = BTN_AUX2;
  localparam logic [2:0] BTN_LANE_NEXT = BTN_AUX3;
  localparam logic [2:0] BTN_LANE_PREV = BTN_AUX4;

  // Setting register indexes.
  localparam logic [2:0] REG_AUX1_COUNT = 3'd0;
  localparam logic [2:0] REG_AUX2_COUNT = 3'd1;
  localparam logic [2:0] REG_AUX3_COUNT = 3'd2;
  localparam logic [2:0] REG_AUX4_COUNT = 3'd3;
  localparam logic [2:0] REG_TRIM_STEP  = 3'd4;
  localparam logic [2:0] REG_TRIM_LIMIT = 3'd5;
  localparam logic [2:0] REG_SPARE      = 3'd6;

  // Trim lanes, indexed as trim_select.
  localparam int LANE_YAW      = 0;
  localparam int LANE_THROTTLE = 1;
  localparam int LANE_PITCH    = 2;
  localparam int LANE_ROLL     = 3;

  // Slave-side tdata, declared from the top bit down.
  typedef struct packed {
    logic                           spare;
    logic [LANES-1:0]               aux_levels;
    logic [LANES-1:0][SAMPLE_W-1:0] aux_raw;
    logic [SAMPLE_W-1:0]            roll_raw, pitch_raw, yaw_raw, throttle_raw;
    logic [2:0]                     button;
  } sample_set_t;

  // Master-side tdata, declared from the top bit down.
  typedef struct packed {
    logic                            spare;
    logic [LANE_W-1:0]               trim_select;
    logic                            trim_mode;
    logic [LANES-1:0][AUX_OUT_W-1:0] aux_out;
    logic [STICK_OUT_W-1:0]          roll_out, pitch_out, yaw_out, throttle_out;
  } channel_frame_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [2:0]            cfg_index_i;
  logic [6:0]            cfg_data_i;

  rc_stick_trim_aux_channel_mapper_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // Predictor copy of the block state and settings.
  logic                trim_on;
  logic [LANE_W-1:0]   trim_lane;
  logic [STATE_W-1:0]  switch_pos [LANES];
  int                  trim_value [LANES];
  logic [COUNT_W-1:0]  aux_count  [LANES];
  logic [3:0]          step_width;
  logic [6:0]          limit_value;

  channel_frame_t pending_frames [$];

  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_request;
  int hold_left;
  int failures;
  int items_sent;
  int frames_seen;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Piecewise stick curve: 1000..1500 below the split point, 1500..2000 above.
  function automatic int stick_curve(input logic [SAMPLE_W-1:0] raw);
    int v;
    v = raw;
    if (v < int'(MAP_MID)) return 1000 + v * 500 / int'(MAP_MID);
    return 1500 + (v - int'(MAP_MID)) * 500 / int'(SAMPLE_MAX - MAP_MID);
  endfunction

  // A state count above eight behaves as eight.
  function automatic int fitted_count(input int a);
    int c;
    c = aux_count[a];
    return (c > 8) ? 8 : c;
  endfunction

  function automatic void apply_press(input logic [2:0] b);
    int a;
    int c;
    int t;
    int lim;
    int s;
    // Drop button indexes beyond the fitted buttons.
    if (b >= BUTTONS || b > BTN_AUX4) return;
    if (b == BTN_FUNCTION) begin
      trim_on   = ~trim_on;
      trim_lane = '0;
      return;
    end
    a = b - 1;
    c = fitted_count(a);
    // An aux channel in analog or digital mode has no button fitted.
    if (c <= 1) return;
    if (trim_on) begin
      case (b)
        BTN_TRIM_DOWN, BTN_TRIM_UP: begin
          lim = limit_value;
          t = trim_value[trim_lane];
          t = (b == BTN_TRIM_UP) ? t + int'(step_width) : t - int'(step_width);
          if (t > lim) t = lim;
          else if (t < -lim) t = -lim;
          trim_value[trim_lane] = t;
        end
        BTN_LANE_NEXT: trim_lane = trim_lane + 1'b1;
        default:       trim_lane = trim_lane - 1'b1;
      endcase
    end else begin
      // A stale state at or past the top wraps to zero.
      s = switch_pos[a] + 1;
      if (s > c - 1) s = 0;
      switch_pos[a] = STATE_W'(s);
    end
  endfunction

  function automatic int stick_pulse(input logic [SAMPLE_W-1:0] raw, input int lane);
    int v;
    v = stick_curve(raw) + trim_value[lane] * int'(step_width);
    if (v < 0) v = 0;
    if (v > 3000) v = 3000;
    return v;
  endfunction

  function automatic int aux_pulse(input int a, input logic [SAMPLE_W-1:0] raw,
                                   input logic [LANES-1:0] levels);
    int c;
    int v;
    int pos;
    c = fitted_count(a);
    if (c == 0) return stick_curve(raw);
    if (c == 1) return levels[a] ? 2000 : 1000;
    pos = switch_pos[a];
    v = 1000 + pos * 1000 / (c - 1);
    return (v > 2000) ? 2000 : v;
  endfunction

  // Apply the optional press, then map the sample set onto the eight channels.
  function automatic channel_frame_t map_channels(input logic cmd, input sample_set_t s);
    channel_frame_t f;
    f = '0;
    if (cmd == CMD_PRESS) apply_press(s.button);
    f.throttle_out = STICK_OUT_W'(stick_pulse(s.throttle_raw, LANE_THROTTLE));
    f.yaw_out      = STICK_OUT_W'(stick_pulse(s.yaw_raw, LANE_YAW));
    f.pitch_out    = STICK_OUT_W'(stick_pulse(s.pitch_raw, LANE_PITCH));
    f.roll_out     = STICK_OUT_W'(stick_pulse(s.roll_raw, LANE_ROLL));
    for (int a = 0; a < LANES; a++)
      f.aux_out[a] = AUX_OUT_W'(aux_pulse(a, s.aux_raw[a], s.aux_levels));
    f.trim_mode   = trim_on;
    f.trim_select = trim_lane;
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Favor the curve ends and the split point over plain random samples.
  function automatic logic [SAMPLE_W-1:0] random_raw();
    case ($urandom_range(15))
      0:       return '0;
      1:       return SAMPLE_W'(SAMPLE_MAX);
      2:       return SAMPLE_W'(MAP_MID - 1);
      3:       return SAMPLE_W'(MAP_MID);
      4:       return SAMPLE_W'(MAP_MID + 1);
      default: return SAMPLE_W'($urandom_range(SAMPLE_MAX));
    endcase
  endfunction

  function automatic sample_set_t random_set(input logic [2:0] btn);
    sample_set_t s;
    s = '0;
    s.button       = btn;
    s.throttle_raw = random_raw();
    s.yaw_raw      = random_raw();
    s.pitch_raw    = random_raw();
    s.roll_raw     = random_raw();
    for (int a = 0; a < LANES; a++) s.aux_raw[a] = random_raw();
    s.aux_levels   = LANES'($urandom_range(15));
    return s;
  endfunction

  function automatic sample_set_t uniform_set(input logic [2:0] btn,
                                              input logic [SAMPLE_W-1:0] raw,
                                              input logic [LANES-1:0] levels);
    sample_set_t s;
    s = '0;
    s.button       = btn;
    s.throttle_raw = raw;
    s.yaw_raw      = raw;
    s.pitch_raw    = raw;
    s.roll_raw     = raw;
    for (int a = 0; a < LANES; a++) s.aux_raw[a] = raw;
    s.aux_levels   = levels;
    return s;
  endfunction

  // Mostly switch counts, now and then anything the register holds.
  function automatic logic [COUNT_W-1:0] random_count();
    if ($urandom_range(3) != 0) return COUNT_W'($urandom_range(8, 2));
    return COUNT_W'($urandom_range(15));
  endfunction

  // Offer one sample set and hold it until the slave side takes the transaction.
  task automatic send_sample(input logic cmd, input sample_set_t s);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= s;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    pending_frames.push_back(map_channels(cmd, s));
    items_sent++;
  endtask

  // Stop offering and wait for every predicted frame, plus a settle margin.
  task automatic drain_frames();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one setting while the block is idle and mirror it in the predictor.
  task automatic write_setting(input logic [2:0] idx, input logic [6:0] value);
    drain_frames();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_AUX1_COUNT, REG_AUX2_COUNT, REG_AUX3_COUNT, REG_AUX4_COUNT:
        aux_count[idx[LANE_W-1:0]] = value[COUNT_W-1:0];
      REG_TRIM_STEP:  step_width  = value[3:0];
      REG_TRIM_LIMIT: limit_value = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_sample_extremes();
    // Command zero ignores whatever the button field holds.
    send_sample(CMD_SAMPLE, uniform_set(BTN_NONE_7, '0, 4'h0));
    send_sample(CMD_SAMPLE, uniform_set(BTN_FUNCTION, SAMPLE_W'(SAMPLE_MAX), 4'hF));
    send_sample(CMD_SAMPLE, uniform_set(BTN_AUX1, SAMPLE_W'(MAP_MID), 4'h5));
  endtask

  task automatic test_aux_switches();
    // Two-state switches: the second press of aux1 wraps back to zero.
    send_sample(CMD_PRESS, random_set(BTN_AUX1));
    send_sample(CMD_PRESS, random_set(BTN_AUX1));
    send_sample(CMD_PRESS, random_set(BTN_AUX2));
    send_sample(CMD_PRESS, random_set(BTN_AUX3));
    send_sample(CMD_PRESS, random_set(BTN_AUX4));
    // Unknown button index is dropped.
    send_sample(CMD_PRESS, random_set(BTN_NONE_5));
  endtask

  task automatic test_trim_control();
    send_sample(CMD_PRESS, random_set(BTN_FUNCTION));
    send_sample(CMD_PRESS, random_set(BTN_TRIM_UP));
    send_sample(CMD_PRESS, random_set(BTN_LANE_NEXT));
    send_sample(CMD_PRESS, random_set(BTN_LANE_PREV));
    // Selection wraps from yaw down to roll.
    send_sample(CMD_PRESS, random_set(BTN_LANE_PREV));
    send_sample(CMD_PRESS, random_set(BTN_TRIM_DOWN));
    // Wide step against a small limit: the third raise clamps.
    write_setting(REG_TRIM_STEP, 7'd15);
    write_setting(REG_TRIM_LIMIT, 7'd30);
    repeat (3) send_sample(CMD_PRESS, uniform_set(BTN_TRIM_UP, SAMPLE_W'(SAMPLE_MAX), 4'h0));
    // Lowered limit keeps the stored trim until the next press of that stick.
    write_setting(REG_TRIM_LIMIT, 7'd5);
    send_sample(CMD_SAMPLE, random_set(BTN_NONE_7));
    send_sample(CMD_PRESS, random_set(BTN_TRIM_DOWN));
    // Zero step changes no trim and zeroes the trim product.
    write_setting(REG_TRIM_STEP, 7'd0);
    send_sample(CMD_PRESS, random_set(BTN_TRIM_UP));
    write_setting(REG_TRIM_STEP, 7'd3);
    write_setting(REG_TRIM_LIMIT, 7'd0);
    send_sample(CMD_PRESS, random_set(BTN_TRIM_UP));
    send_sample(CMD_PRESS, random_set(BTN_FUNCTION));
  endtask

  task automatic test_missing_buttons_and_stale_state();
    write_setting(REG_AUX1_COUNT, 7'd0);
    write_setting(REG_AUX2_COUNT, 7'd1);
    write_setting(REG_AUX3_COUNT, 7'd9);
    write_setting(REG_AUX4_COUNT, 7'd4);
    // Spare index must leave every setting alone.
    write_setting(REG_SPARE, 7'h7F);
    send_sample(CMD_SAMPLE, random_set(BTN_AUX1));
    // Analog and digital channels have no button: presses do nothing.
    send_sample(CMD_PRESS, random_set(BTN_AUX1));
    send_sample(CMD_PRESS, random_set(BTN_AUX2));
    // Drive aux4 to state three, then lower its count to three (states 0 to 2).
    send_sample(CMD_PRESS, random_set(BTN_AUX4));
    send_sample(CMD_PRESS, random_set(BTN_AUX4));
    write_setting(REG_AUX4_COUNT, 7'd3);
    send_sample(CMD_SAMPLE, random_set(BTN_AUX4));
    send_sample(CMD_PRESS, random_set(BTN_AUX4));
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    // Stall the master side long enough for the block to refuse input.
    hold_request = 1'b1;
    repeat (24) send_sample(1'($urandom_range(1)), random_set(3'($urandom_range(7))));
    drain_frames();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct,
                                     input logic [COUNT_W-1:0] c1, input logic [COUNT_W-1:0] c2,
                                     input logic [COUNT_W-1:0] c3, input logic [COUNT_W-1:0] c4,
                                     input logic [3:0] step, input logic [6:0] lim);
    int burst_left;
    logic [2:0] burst_btn;
    logic cmd;
    write_setting(REG_AUX1_COUNT, 7'(c1));
    write_setting(REG_AUX2_COUNT, 7'(c2));
    write_setting(REG_AUX3_COUNT, 7'(c3));
    write_setting(REG_AUX4_COUNT, 7'(c4));
    write_setting(REG_TRIM_STEP, 7'(step));
    write_setting(REG_TRIM_LIMIT, lim);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    burst_left  = 0;
    burst_btn   = BTN_FUNCTION;
    // Repeat the same button for a while so trims sweep into their clamps.
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (burst_left == 0) begin
        if ($urandom_range(9) == 0) burst_btn = 3'($urandom_range(7));
        else burst_btn = 3'($urandom_range(4));
        burst_left = (burst_btn == BTN_FUNCTION) ? 1 : $urandom_range(12, 1);
      end
      cmd = ($urandom_range(99) < 60);
      if (cmd) burst_left--;
      send_sample(cmd, random_set(cmd ? burst_btn : 3'($urandom_range(7))));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Master side: random ready, plus a long hold-off on request.
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  // Compare each output transaction with the oldest predicted frame.
  always @(posedge clk_i) begin
    channel_frame_t want;
    channel_frame_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_frames.size() == 0) begin
        $error("channel frame with no sample set waiting for it");
        failures++;
      end else begin
        want = pending_frames.pop_front();
        check_field("throttle_out", want.throttle_out, got.throttle_out);
        check_field("yaw_out", want.yaw_out, got.yaw_out);
        check_field("pitch_out", want.pitch_out, got.pitch_out);
        check_field("roll_out", want.roll_out, got.roll_out);
        for (int a = 0; a < LANES; a++)
          check_field($sformatf("aux%0d_out", a + 1), want.aux_out[a], got.aux_out[a]);
        check_field("trim_mode", want.trim_mode, got.trim_mode);
        check_field("trim_select", want.trim_select, got.trim_select);
        frames_seen++;
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_SAMPLE;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = REG_AUX1_COUNT;
    cfg_data_i    = '0;
    hold_request  = 1'b0;
    hold_left     = 0;
    failures      = 0;
    items_sent    = 0;
    frames_seen   = 0;
    cycle_count   = 0;
    tx_idle_pct   = 25;
    rx_idle_pct   = 25;
    trim_on       = 1'b0;
    trim_lane     = '0;
    for (int a = 0; a < LANES; a++) begin
      switch_pos[a] = '0;
      trim_value[a] = 0;
      aux_count[a]  = 4'd2;
    end
    step_width  = 4'd1;
    limit_value = 7'd20;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sample_extremes();
    test_aux_switches();
    test_trim_control();
    test_missing_buttons_and_stale_state();
    test_output_backpressure();
    // Widest trim product, switches only, then random and fixed settings.
    test_random_traffic(12, 66, 4'd8, 4'd2, 4'd3, 4'd15, 4'd15, 7'd127);
    test_random_traffic(66, 12, random_count(), random_count(), random_count(),
                        random_count(), 4'($urandom_range(15)), 7'($urandom_range(127)));
    test_random_traffic(0, 0, random_count(), random_count(), random_count(),
                        random_count(), 4'd10, 7'd100);
    drain_frames();

    $display("Ran %0d sample sets and checked %0d channel frames in %0d cycles.",
             items_sent, frames_seen, cycle_count);
    $display("Covered curve ends, trim sweeps and clamps, switch wrap, unfitted buttons, stalls.");
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ rc_stick_trim_aux_channel_mapper_unit.f @@
hw/rtl/rcst_pkg.sv
hw/rtl/rcst_map.sv
hw/rtl/rcst_ctrl.sv
hw/rtl/rcst_datapath.sv
hw/rtl/rc_stick_trim_aux_channel_mapper_unit.sv
test/testbench.sv
